[sv/lzd_pkg.sv]
// shared types and constants for the lz77 byte stream decoder
`timescale 1ns / 1ps
package lzd_pkg;

	localparam int unsigned CAP_W     = 25;
	localparam logic [CAP_W-1:0] CAP_RESET = 25'd4194304;
	localparam logic [7:0] WIN_MIN = 8'd10;
	localparam logic [7:0] WIN_MAX = 8'd24;
	localparam int unsigned MAGIC_LEN = 4;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_MARKER,
		PH_LIT_LEN,
		PH_LIT_BYTES,
		PH_DIST_LO,
		PH_DIST_HI,
		PH_MATCH_LEN,
		PH_DRAIN
	} phase_t;

	typedef enum logic [3:0] {
		STAT_DATA     = 4'd0,
		STAT_END      = 4'd1,
		STAT_MAGIC    = 4'd2,
		STAT_WINDOW   = 4'd3,
		STAT_TRUNC    = 4'd4,
		STAT_MARKER   = 4'd5,
		STAT_DISTANCE = 4'd6,
		STAT_OVERFLOW = 4'd7,
		STAT_EMPTY    = 4'd8
	} status_t;

	typedef enum logic [7:0] {
		MK_LITERAL = 8'd0,
		MK_MATCH   = 8'd1,
		MK_END     = 8'd2
	} marker_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_COPY_RD,
		S_COPY_WR,
		S_EMIT
	} ctrl_state_t;

	// controller commands to the datapath
	typedef struct packed {
		logic accept;
		logic copy_rd;
		logic copy_wr;
		logic emit;
	} lzd_cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic out_free;
		logic start_copy;
		logic flush_needed;
		logic copy_done;
	} lzd_stat_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] v;
		unique case (idx)
			2'd0: v = 8'hCE;
			2'd1: v = 8'hB2;
			2'd2: v = 8'hCF;
			default: v = 8'h81;
		endcase
		return v;
	endfunction

endpackage

[sv/lzd_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
module lzd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

[sv/lzd_ctrl.sv]
// controller state machine: byte intake, match copy and result emission
`timescale 1ns / 1ps
module lzd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lzd_pkg::lzd_stat_t stat,
	output lzd_pkg::lzd_cmd_t  cmd
);
	import lzd_pkg::*;

	ctrl_state_t state_q, state_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && stat.out_free && stat.start_copy) begin
					state_n = S_COPY_RD;
				end
			end
			S_COPY_RD: state_n = S_COPY_WR;
			S_COPY_WR: state_n = stat.flush_needed ? S_EMIT : S_COPY_RD;
			S_EMIT: begin
				if (stat.out_free) begin
					state_n = stat.copy_done ? S_IDLE : S_COPY_RD;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd.accept  = (state_q == S_IDLE) && in_valid && stat.out_free;
		cmd.copy_rd = (state_q == S_COPY_RD);
		cmd.copy_wr = (state_q == S_COPY_WR);
		cmd.emit    = (state_q == S_EMIT) && stat.out_free;
		in_stall    = !((state_q == S_IDLE) && stat.out_free);
	end

	// a read is always followed by its write
	a_rd_then_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.copy_rd |=> cmd.copy_wr)
		else $error("copy read not followed by write");
	// no byte taken while a copy runs
	a_no_accept_in_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.copy_rd || cmd.copy_wr) |-> !cmd.accept)
		else $error("byte accepted during copy");
	// an emit that finishes the copy returns to intake
	a_emit_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && stat.copy_done) |=> (state_q == S_IDLE))
		else $error("copy end did not return to idle");

endmodule

[sv/lzd_dp.sv]
// datapath: stream parser registers, history memory, packing and output register
`timescale 1ns / 1ps
module lzd_dp #(
	parameter int unsigned HISTORY_DEPTH = 65536
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lzd_pkg::CAP_W-1:0]  cfg_wdata,
	input  logic [7:0]                 in_byte,
	input  logic                       last_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 out_byte0,
	output logic [7:0]                 out_byte1,
	output logic [7:0]                 out_byte2,
	output logic [7:0]                 out_byte3,
	output logic [2:0]                 byte_count,
	output logic [3:0]                 status,
	output logic                       last_result,
	input  lzd_pkg::lzd_cmd_t          cmd,
	output lzd_pkg::lzd_stat_t         stat
);
	import lzd_pkg::*;

	localparam int unsigned AW = $clog2(HISTORY_DEPTH);

	logic [CAP_W-1:0] cap_q;
	phase_t           phase_q, ph_n;
	logic [2:0]       idx_q, idx_n;
	logic [7:0]       run_q, run_n;
	logic [15:0]      dist_q, dist_n;
	logic [CAP_W-1:0] bw_q, bw_n, bw_inc;
	logic             pend_last_q;
	logic [7:0]       left_q;
	logic [7:0]       pack_q [4];
	logic [2:0]       pack_cnt_q;

	logic             term, lit_wr, start_copy, emit_now;
	status_t          st;
	logic [CAP_W:0]   sum_len;
	logic             ovf;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [7:0]       ram_wdata, ram_rdata;

	logic             out_valid_q;
	logic [7:0]       ob_q [4];
	logic [2:0]       cnt_q;
	logic [3:0]       stat_q;
	logic             lastr_q;

	assign bw_inc  = bw_q + 1'b1;
	assign sum_len = {1'b0, bw_q} + {{(CAP_W-7){1'b0}}, in_byte};
	assign ovf     = sum_len > {1'b0, cap_q};

	// decode of one accepted byte
	always_comb begin
		ph_n       = phase_q;
		idx_n      = idx_q;
		run_n      = run_q;
		dist_n     = dist_q;
		bw_n       = bw_q;
		term       = 1'b0;
		st         = STAT_DATA;
		lit_wr     = 1'b0;
		start_copy = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				if (last_byte) begin
					term = 1'b1; st = STAT_TRUNC;
				end else if (idx_q < 3'(MAGIC_LEN)) begin
					if (in_byte != magic_byte(idx_q[1:0])) begin
						term = 1'b1; st = STAT_MAGIC;
					end else begin
						idx_n = idx_q + 3'd1;
					end
				end else if (in_byte < WIN_MIN || in_byte > WIN_MAX) begin
					term = 1'b1; st = STAT_WINDOW;
				end else begin
					ph_n = PH_MARKER; idx_n = 3'd0;
				end
			end
			PH_MARKER: begin
				if (in_byte == MK_LITERAL || in_byte == MK_MATCH) begin
					if (last_byte) begin
						term = 1'b1; st = STAT_TRUNC;
					end else begin
						ph_n = (in_byte == MK_LITERAL) ? PH_LIT_LEN : PH_DIST_LO;
					end
				end else if (in_byte == MK_END) begin
					term = 1'b1;
					st = (bw_q == '0) ? STAT_EMPTY : STAT_END;
				end else begin
					term = 1'b1; st = STAT_MARKER;
				end
			end
			PH_LIT_LEN: begin
				if (ovf) begin
					term = 1'b1; st = STAT_OVERFLOW;
				end else if (in_byte == 8'd0) begin
					ph_n = PH_MARKER;
				end else if (last_byte) begin
					term = 1'b1; st = STAT_TRUNC;
				end else begin
					run_n = in_byte; ph_n = PH_LIT_BYTES;
				end
			end
			PH_LIT_BYTES: begin
				lit_wr = 1'b1;
				bw_n   = bw_inc;
				run_n  = run_q - 8'd1;
				if (run_n == 8'd0) begin
					ph_n = PH_MARKER;
				end else if (last_byte) begin
					term = 1'b1; st = STAT_TRUNC;
				end
			end
			PH_DIST_LO: begin
				dist_n = {8'd0, in_byte};
				if (last_byte) begin
					term = 1'b1; st = STAT_TRUNC;
				end else begin
					ph_n = PH_DIST_HI;
				end
			end
			PH_DIST_HI: begin
				dist_n = {in_byte, dist_q[7:0]};
				if (last_byte) begin
					term = 1'b1; st = STAT_TRUNC;
				end else begin
					ph_n = PH_MATCH_LEN;
				end
			end
			PH_MATCH_LEN: begin
				if (dist_q == 16'd0 || {{(CAP_W-16){1'b0}}, dist_q} > bw_q) begin
					term = 1'b1; st = STAT_DISTANCE;
				end else if (ovf) begin
					term = 1'b1; st = STAT_OVERFLOW;
				end else begin
					start_copy = (in_byte != 8'd0);
					ph_n = PH_MARKER;
				end
			end
			PH_DRAIN: begin
			end
			default: begin
			end
		endcase
		// stream closed cleanly on its last byte
		if (!term && !start_copy && last_byte && ph_n == PH_MARKER) begin
			term = 1'b1;
			st = (bw_n == '0) ? STAT_EMPTY : STAT_END;
		end
		if (term) begin
			ph_n = PH_DRAIN;
		end
		emit_now = term || lit_wr;
	end

	assign stat.out_free     = !out_valid_q || !out_stall;
	assign stat.start_copy   = start_copy;
	assign stat.flush_needed = (pack_cnt_q == 3'd3) || (left_q == 8'd1);
	assign stat.copy_done    = (left_q == 8'd0);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// parser state, byte count and copy control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			idx_q       <= 3'd0;
			run_q       <= 8'd0;
			dist_q      <= 16'd0;
			bw_q        <= '0;
			pend_last_q <= 1'b0;
			left_q      <= 8'd0;
			pack_cnt_q  <= 3'd0;
		end else begin
			if (cmd.accept) begin
				if (last_byte && !start_copy) begin
					phase_q <= PH_HEADER;
					idx_q   <= 3'd0;
					run_q   <= 8'd0;
					dist_q  <= 16'd0;
					bw_q    <= '0;
				end else begin
					phase_q <= ph_n;
					idx_q   <= idx_n;
					run_q   <= run_n;
					dist_q  <= dist_n;
					bw_q    <= bw_n;
				end
				if (start_copy) begin
					left_q      <= in_byte;
					pend_last_q <= last_byte;
				end
			end
			if (cmd.copy_wr) begin
				bw_q       <= bw_inc;
				left_q     <= left_q - 8'd1;
				pack_cnt_q <= pack_cnt_q + 3'd1;
			end
			if (cmd.emit) begin
				pack_cnt_q <= 3'd0;
				if (left_q == 8'd0 && pend_last_q) begin
					phase_q     <= PH_HEADER;
					idx_q       <= 3'd0;
					run_q       <= 8'd0;
					dist_q      <= 16'd0;
					bw_q        <= '0;
					pend_last_q <= 1'b0;
				end
			end
		end
	end

	// packing buffer for copied bytes
	always_ff @(posedge clk) begin
		if (cmd.copy_wr) begin
			pack_q[pack_cnt_q[1:0]] <= ram_rdata;
		end
	end

	// history memory ports
	assign ram_we    = (cmd.accept && lit_wr) || cmd.copy_wr;
	assign ram_waddr = bw_q[AW-1:0];
	assign ram_wdata = cmd.copy_wr ? ram_rdata : in_byte;
	assign ram_raddr = AW'(bw_q - {{(CAP_W-16){1'b0}}, dist_q});

	lzd_ram #(
		.WIDTH(8),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr  (ram_raddr),
		.rdata_q(ram_rdata)
	);

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.accept && emit_now && !start_copy) || cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.accept && emit_now && !start_copy) begin
			ob_q[0] <= lit_wr ? in_byte : 8'd0;
			ob_q[1] <= 8'd0;
			ob_q[2] <= 8'd0;
			ob_q[3] <= 8'd0;
			cnt_q   <= lit_wr ? 3'd1 : 3'd0;
			stat_q  <= st;
			lastr_q <= 1'b1;
		end else if (cmd.emit) begin
			for (int j = 0; j < 4; j++) begin
				ob_q[j] <= (3'(j) < pack_cnt_q) ? pack_q[j] : 8'd0;
			end
			cnt_q   <= pack_cnt_q;
			stat_q  <= (left_q == 8'd0 && pend_last_q) ? STAT_END : STAT_DATA;
			lastr_q <= (left_q == 8'd0);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte0   = ob_q[0];
	assign out_byte1   = ob_q[1];
	assign out_byte2   = ob_q[2];
	assign out_byte3   = ob_q[3];
	assign byte_count  = cnt_q;
	assign status      = stat_q;
	assign last_result = lastr_q;

	// packing never exceeds one result
	a_pack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pack_cnt_q <= 3'd4)
		else $error("packing count overflow");
	// copy flushes only with bytes in hand
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (pack_cnt_q != 3'd0))
		else $error("empty copy result");
	// each copied byte advances the write count
	a_copy_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.copy_wr |=> (bw_q == CAP_W'($past(bw_q) + 1'b1)))
		else $error("write count not advanced on copy");

endmodule

[sv/lz77_byte_stream_decoder.sv]
// top level of the lz77 byte stream decoder
`timescale 1ns / 1ps
// Byte-serial LZ77 stream decoder. Header, marker, length, distance and
// literal bytes are taken one per cycle whenever the output register is
// free; each yields at most one result, but a match of length L yields
// one per group of up to four copied bytes and stops input while it is
// expanded from the 64 KiB history memory: each copied byte takes a
// registered memory read, then a write back, and each group is then
// loaded into the output register, waiting on any output stall. Errors
// and the end status ride on the last result of a byte; after them bytes
// are dropped until last_byte. The history memory is not cleared; a
// stream only reads entries it wrote itself.
module lz77_byte_stream_decoder #(
	parameter int unsigned HISTORY_DEPTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [24:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte0,
	output logic [7:0]  out_byte1,
	output logic [7:0]  out_byte2,
	output logic [7:0]  out_byte3,
	output logic [2:0]  byte_count,
	output logic [3:0]  status,
	output logic        last_result
);
	import lzd_pkg::*;

	lzd_cmd_t  cmd;
	lzd_stat_t stat;

	// sequencing of intake, copy and emission
	lzd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	// parser, history and output register
	lzd_dp #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_byte    (in_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte0  (out_byte0),
		.out_byte1  (out_byte1),
		.out_byte2  (out_byte2),
		.out_byte3  (out_byte3),
		.byte_count (byte_count),
		.status     (status),
		.last_result(last_result),
		.cmd        (cmd),
		.stat       (stat)
	);

endmodule

[dv/lz77_byte_stream_decoder_test.sv]
// testbench for the lz77 byte stream decoder: stream stimulus, result prediction and checking
`timescale 1ns / 1ps
module lz77_byte_stream_decoder_test;
	import lzd_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       fin;
	} stream_byte_t;

	typedef struct {
		logic [7:0] b0, b1, b2, b3;
		logic [2:0] cnt;
		status_t    st;
		logic       fin;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [24:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte0, out_byte1, out_byte2, out_byte3;
	logic [2:0]  byte_count;
	logic [3:0]  status;
	logic        last_result;

	stream_byte_t pending_bytes[$];
	beat_t        expected_beats[$];
	int           mismatches = 0;
	int           send_gap = 0;
	int           recv_gap = 0;
	int           sent_count = 0;
	bit           no_idle = 1'b0;

	// decoder state mirror
	logic [24:0] capacity = CAP_RESET;
	phase_t      ph = PH_HEADER;
	int          hdr_idx = 0;
	int          run_left = 0;
	int          match_dist = 0;
	int          written = 0;
	logic [7:0]  history[65536];

	// generator-side count of bytes written in the stream under construction
	int          gen_written;

	lz77_byte_stream_decoder DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
		.last_byte(last_byte), .out_valid(out_valid), .out_stall(out_stall),
		.out_byte0(out_byte0), .out_byte1(out_byte1), .out_byte2(out_byte2),
		.out_byte3(out_byte3), .byte_count(byte_count), .status(status),
		.last_result(last_result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// expand one compressed byte into the result beats it produces
	task automatic decode_byte(input logic [7:0] b, input logic fin);
		logic [7:0] produced[$];
		bit         term;
		status_t    st;
		int         nres;
		int         base;
		int         cnt;
		beat_t      r;
		logic [7:0] v;
		term = 1'b0;
		st = STAT_DATA;
		case (ph)
			PH_HEADER: begin
				if (fin) begin
					term = 1; st = STAT_TRUNC;
				end else if (hdr_idx < MAGIC_LEN) begin
					v = (hdr_idx == 0) ? 8'hCE : (hdr_idx == 1) ? 8'hB2 :
						(hdr_idx == 2) ? 8'hCF : 8'h81;
					if (b != v) begin
						term = 1; st = STAT_MAGIC;
					end else hdr_idx++;
				end else if (b < WIN_MIN || b > WIN_MAX) begin
					term = 1; st = STAT_WINDOW;
				end else begin
					ph = PH_MARKER; hdr_idx = 0;
				end
			end
			PH_MARKER: begin
				if (b == MK_LITERAL || b == MK_MATCH) begin
					if (fin) begin
						term = 1; st = STAT_TRUNC;
					end else ph = (b == MK_LITERAL) ? PH_LIT_LEN : PH_DIST_LO;
				end else if (b == MK_END) begin
					term = 1; st = (written == 0) ? STAT_EMPTY : STAT_END;
				end else begin
					term = 1; st = STAT_MARKER;
				end
			end
			PH_LIT_LEN: begin
				if (written + b > capacity) begin
					term = 1; st = STAT_OVERFLOW;
				end else if (b == 0) ph = PH_MARKER;
				else if (fin) begin
					term = 1; st = STAT_TRUNC;
				end else begin
					run_left = b; ph = PH_LIT_BYTES;
				end
			end
			PH_LIT_BYTES: begin
				history[written[15:0]] = b;
				written = (written + 1) & 32'h1FFFFFF;
				produced.push_back(b);
				run_left--;
				if (run_left == 0) ph = PH_MARKER;
				else if (fin) begin
					term = 1; st = STAT_TRUNC;
				end
			end
			PH_DIST_LO: begin
				match_dist = b;
				if (fin) begin
					term = 1; st = STAT_TRUNC;
				end else ph = PH_DIST_HI;
			end
			PH_DIST_HI: begin
				match_dist = match_dist + (b << 8);
				if (fin) begin
					term = 1; st = STAT_TRUNC;
				end else ph = PH_MATCH_LEN;
			end
			PH_MATCH_LEN: begin
				if (match_dist == 0 || match_dist > written) begin
					term = 1; st = STAT_DISTANCE;
				end else if (written + b > capacity) begin
					term = 1; st = STAT_OVERFLOW;
				end else begin
					for (int i = 0; i < b; i++) begin
						v = history[(written - match_dist) & 16'hFFFF];
						history[written[15:0]] = v;
						written = (written + 1) & 32'h1FFFFFF;
						produced.push_back(v);
					end
					ph = PH_MARKER;
				end
			end
			default: ;
		endcase
		if (!term && fin && ph == PH_MARKER) begin
			term = 1; st = (written == 0) ? STAT_EMPTY : STAT_END;
		end
		// pack up to four bytes per beat, terminal status on the final beat
		nres = (produced.size() + 3) / 4;
		if (nres == 0 && term) nres = 1;
		for (int k = 0; k < nres; k++) begin
			base = k * 4;
			cnt = produced.size() - base;
			if (cnt < 0) cnt = 0;
			if (cnt > 4) cnt = 4;
			r.b0 = (cnt > 0) ? produced[base] : 8'd0;
			r.b1 = (cnt > 1) ? produced[base + 1] : 8'd0;
			r.b2 = (cnt > 2) ? produced[base + 2] : 8'd0;
			r.b3 = (cnt > 3) ? produced[base + 3] : 8'd0;
			r.cnt = cnt[2:0];
			r.st = (term && k == nres - 1) ? st : STAT_DATA;
			r.fin = (k == nres - 1);
			expected_beats.push_back(r);
		end
		if (term) ph = PH_DRAIN;
		if (fin) begin
			ph = PH_HEADER; hdr_idx = 0; run_left = 0; match_dist = 0; written = 0;
		end
	endtask

	// input driver: one transaction per queued byte with random gaps
	always @(posedge clk) begin
		bit         accepted;
		stream_byte_t sb;
		accepted = in_valid && !in_stall;
		if (accepted) begin
			decode_byte(in_byte, last_byte);
			sent_count++;
			if (sent_count % 53 == 0) no_idle = !no_idle;
			send_gap = no_idle ? 0 : $urandom_range(0, 4);
		end
		if (!in_valid || accepted) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				sb = pending_bytes.pop_front();
				in_byte <= sb.data;
				last_byte <= sb.fin;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor and output stall generator
	always @(posedge clk) begin
		beat_t exp_b;
		if (out_valid && !out_stall) begin
			if (expected_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: bytes %h %h %h %h cnt %0d st %0d last %0b",
						out_byte0, out_byte1, out_byte2, out_byte3, byte_count, status,
						last_result);
			end else begin
				exp_b = expected_beats.pop_front();
				if (out_byte0 !== exp_b.b0 || out_byte1 !== exp_b.b1 ||
					out_byte2 !== exp_b.b2 || out_byte3 !== exp_b.b3 ||
					byte_count !== exp_b.cnt || status !== exp_b.st ||
					last_result !== exp_b.fin) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: exp %h %h %h %h cnt %0d st %0d last %0b, got %h %h %h %h cnt %0d st %0d last %0b",
							exp_b.b0, exp_b.b1, exp_b.b2, exp_b.b3, exp_b.cnt, exp_b.st,
							exp_b.fin, out_byte0, out_byte1, out_byte2, out_byte3,
							byte_count, status, last_result);
				end
			end
			recv_gap = no_idle ? 0 : $urandom_range(0, 4);
		end
		if (recv_gap > 0) begin
			recv_gap--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic put(input logic [7:0] b, input logic fin = 1'b0);
		stream_byte_t sb;
		sb.data = b;
		sb.fin = fin;
		pending_bytes.push_back(sb);
	endtask

	task automatic put_header(input logic [7:0] win);
		put(8'hCE); put(8'hB2); put(8'hCF); put(8'h81); put(win);
	endtask

	// build one random stream; mode 0 well formed, 1 cut short, 2 noise
	task automatic build_stream(input int mode);
		logic [7:0] s[$];
		int         tokens;
		int         len;
		int         d;
		int         cut;
		gen_written = 0;
		if (mode == 2) begin
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++) s.push_back($urandom_range(0, 255));
		end else begin
			s = {8'hCE, 8'hB2, 8'hCF, 8'h81};
			s.push_back($urandom_range(WIN_MIN, WIN_MAX));
			tokens = $urandom_range(1, 6);
			for (int t = 0; t < tokens; t++) begin
				if (gen_written > 0 && $urandom_range(0, 1)) begin
					d = $urandom_range(1, (gen_written > 65535) ? 65535 : gen_written);
					len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) :
						$urandom_range(0, 12);
					s.push_back(MK_MATCH);
					s.push_back(d[7:0]);
					s.push_back(d[15:8]);
					s.push_back(len[7:0]);
				end else begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) :
						$urandom_range(0, 8);
					s.push_back(MK_LITERAL);
					s.push_back(len[7:0]);
					for (int i = 0; i < len; i++) s.push_back($urandom_range(0, 255));
				end
				gen_written += len;
			end
			if ($urandom_range(0, 3) != 0) begin
				s.push_back(MK_END);
				len = $urandom_range(0, 2);
				for (int i = 0; i < len; i++) s.push_back($urandom_range(0, 255));
			end
			if (mode == 1) begin
				cut = $urandom_range(1, s.size());
				while (s.size() > cut) void'(s.pop_back());
			end
		end
		foreach (s[i]) put(s[i], i == s.size() - 1);
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_beats.size() != 0);
		// a header or marker byte leaves no result unless it ends the stream or is in error
		repeat (800) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [24:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity = v;
	endtask

	task automatic random_streams(input int n_items);
		int target;
		int pick;
		target = pending_bytes.size() + n_items;
		while (pending_bytes.size() < target) begin
			pick = $urandom_range(0, 9);
			build_stream((pick < 7) ? 0 : (pick < 9) ? 1 : 2);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// header cut short, bad magic, bad window below and above range
		put(8'hCE); put(8'hB2, 1);
		put(8'hCE); put(8'h00); put(8'h55, 1);
		put_header(8'd9); put(8'h00, 1);
		put_header(8'd25); put(8'hFF, 1);
		// empty stream at the top window value
		put_header(WIN_MAX); put(MK_END, 1);
		// literals, overlapping match, zero-length literal and match
		put_header(WIN_MIN);
		put(MK_LITERAL); put(8'd3); put(8'hAA); put(8'hBB); put(8'hCC);
		put(MK_MATCH); put(8'd1); put(8'd0); put(8'd5);
		put(MK_LITERAL); put(8'd0);
		put(MK_MATCH); put(8'd2); put(8'd0); put(8'd0);
		put(MK_END, 1);
		// distance zero, then dropped bytes
		put_header(8'd12);
		put(MK_LITERAL); put(8'd2); put(8'hFF); put(8'h00);
		put(MK_MATCH); put(8'd0); put(8'd0); put(8'd4); put(8'h77); put(8'h01, 1);
		// distance past the bytes written
		put_header(8'd15);
		put(MK_LITERAL); put(8'd1); put(8'h5A);
		put(MK_MATCH); put(8'd5); put(8'd0); put(8'd3, 1);
		// unknown marker, a marker on the last byte, and a distance byte on the last byte
		put_header(8'd16); put(8'hFF, 1);
		put_header(8'd16); put(MK_LITERAL, 1);
		put_header(8'd16); put(MK_MATCH); put(8'd1, 1);
		// literal run cut short keeps emitted bytes
		put_header(8'd20);
		put(MK_LITERAL); put(8'd4); put(8'h01); put(8'h02, 1);
		// token completing on the last byte ends the stream
		put_header(8'd20);
		put(MK_LITERAL); put(8'd2); put(8'h10); put(8'h20, 1);
		// longest literal run and longest match
		put_header(8'd24);
		put(MK_LITERAL); put(8'd255);
		for (int i = 0; i < 255; i++) put(i[7:0]);
		put(MK_MATCH); put(8'd255); put(8'd0); put(8'd255);
		put(MK_END, 1);
		random_streams(6);
		wait_idle();

		// no room at all: any nonempty literal run overflows
		set_capacity(25'd0);
		put_header(8'd11); put(MK_LITERAL); put(8'd0); put(MK_LITERAL); put(8'd1);
		put(8'h42, 1);
		random_streams(4);
		wait_idle();

		set_capacity(25'd37);
		put_header(8'd11);
		put(MK_LITERAL); put(8'd30);
		for (int i = 0; i < 30; i++) put($urandom_range(0, 255));
		put(MK_MATCH); put(8'd4); put(8'd0); put(8'd8);
		put(MK_END, 1);
		random_streams(6);
		wait_idle();

		set_capacity(25'd16777216);
		random_streams(6);
		wait_idle();

		set_capacity(25'd120);
		random_streams(6);
		wait_idle();

		if (mismatches == 0 && expected_beats.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// run limit
	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
